### hdl/tpi_pkg.sv
// Shared constants and types for the triangle plane interpolator.
package tpi_pkg;

  localparam int DataWidthDef = 32;
  localparam int InFieldCnt = 11;

  typedef struct packed {
    logic eq;
    logic deg;
  } tpi_flags_t;

endpackage

### hdl/triangle_plane_interpolator_core.sv
// Top level of the triangle plane interpolator.
//
//  channel  dir  payload                                             role
//  s_axis   in   tdata: query_x, query_y, p1_x..p3_z (11 x DATA_WIDTH) query + vertices
//  m_axis   out  tdata: value_out; tuser: degenerate, saturated        interpolated z
//
// One transaction per cycle sustained while m_axis_tready stays high; the pipeline is
// 4 normal stages, 3 numerator stages, DATA_WIDTH + 3 divider stages and 1 output stage.
// The divider retires one quotient bit per stage and sets the depth.
// Reset clears only the stage valid bits; every stage holds while its successor
// is full and stalled, and bubbles close up behind a stalled output.
module triangle_plane_interpolator_core #(
  parameter int DATA_WIDTH = tpi_pkg::DataWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // query_x, query_y, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, zero pad
  input  logic [((tpi_pkg::InFieldCnt*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // value_out, zero pad
  output logic [((DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // degenerate, saturated
  output logic [1:0]             m_axis_tuser
);

  localparam int W   = DATA_WIDTH;
  localparam int NW  = 2 * W + 3;
  localparam int MW  = 3 * W + 5;
  localparam int OTW = ((W + 7) / 8) * 8;

  logic                 f_valid, f_ready;
  logic signed [NW-1:0] f_nx, f_ny, f_nz;
  logic signed [W:0]    f_dx, f_dy;
  logic signed [W-1:0]  f_z1;
  tpi_pkg::tpi_flags_t  f_flags;

  logic                 n_valid, n_ready, n_neg;
  logic [MW-1:0]        n_anum;
  logic [NW-1:0]        n_nz;
  logic signed [W-1:0]  n_z1;
  tpi_pkg::tpi_flags_t  n_flags;

  logic                 d_valid, d_ready, d_neg, d_ovf;
  logic [W+1:0]         d_quo;
  logic signed [W-1:0]  d_z1;
  tpi_pkg::tpi_flags_t  d_flags;

  logic signed [W-1:0]  value;
  logic                 degenerate, saturated;

  tpi_front #(.DATA_WIDTH(W)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .in_data_i (s_axis_tdata[tpi_pkg::InFieldCnt*W-1:0]),
    .valid_o   (f_valid),
    .ready_i   (f_ready),
    .nx_o      (f_nx),
    .ny_o      (f_ny),
    .nz_o      (f_nz),
    .dx_o      (f_dx),
    .dy_o      (f_dy),
    .z1_o      (f_z1),
    .flags_o   (f_flags)
  );

  tpi_numer #(.DATA_WIDTH(W)) u_numer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .nx_i    (f_nx),
    .ny_i    (f_ny),
    .nz_i    (f_nz),
    .dx_i    (f_dx),
    .dy_i    (f_dy),
    .z1_i    (f_z1),
    .flags_i (f_flags),
    .valid_o (n_valid),
    .ready_i (n_ready),
    .anum_o  (n_anum),
    .neg_o   (n_neg),
    .nz_o    (n_nz),
    .z1_o    (n_z1),
    .flags_o (n_flags)
  );

  tpi_div #(.DATA_WIDTH(W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n_valid),
    .ready_o (n_ready),
    .anum_i  (n_anum),
    .neg_i   (n_neg),
    .nz_i    (n_nz),
    .z1_i    (n_z1),
    .flags_i (n_flags),
    .valid_o (d_valid),
    .ready_i (d_ready),
    .quo_o   (d_quo),
    .neg_o   (d_neg),
    .ovf_o   (d_ovf),
    .z1_o    (d_z1),
    .flags_o (d_flags)
  );

  tpi_out #(.DATA_WIDTH(W)) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (d_valid),
    .ready_o      (d_ready),
    .quo_i        (d_quo),
    .neg_i        (d_neg),
    .ovf_i        (d_ovf),
    .z1_i         (d_z1),
    .flags_i      (d_flags),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .value_o      (value),
    .degenerate_o (degenerate),
    .saturated_o  (saturated)
  );

  assign m_axis_tdata = OTW'($unsigned(value));
  assign m_axis_tuser = {saturated, degenerate};

endmodule

### hdl/tpi_front.sv
// Edge differences, cross products and the oriented plane normal.
module tpi_front #(
  parameter int DATA_WIDTH = tpi_pkg::DataWidthDef
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          ready_o,
  input  logic [tpi_pkg::InFieldCnt*DATA_WIDTH-1:0]     in_data_i,
  output logic                                          valid_o,
  input  logic                                          ready_i,
  output logic signed [2*DATA_WIDTH+2:0]                nx_o,
  output logic signed [2*DATA_WIDTH+2:0]                ny_o,
  output logic signed [2*DATA_WIDTH+2:0]                nz_o,
  output logic signed [DATA_WIDTH:0]                    dx_o,
  output logic signed [DATA_WIDTH:0]                    dy_o,
  output logic signed [DATA_WIDTH-1:0]                  z1_o,
  output tpi_pkg::tpi_flags_t                           flags_o
);

  localparam int W  = DATA_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int NW = 2 * W + 3;
  localparam int NS = 4;

  logic signed [W-1:0] f [tpi_pkg::InFieldCnt];
  logic [NS-1:0] v_q, en;

  // stage 1
  logic signed [DW-1:0] bx_q, by_q, bz_q, cx_q, cy_q, cz_q, dx1_q, dy1_q;
  logic signed [DW-1:0] bx_d, by_d, bz_d, cx_d, cy_d, cz_d, dx1_d, dy1_d;
  logic signed [W-1:0]  z1a_q;
  logic                 eq1_q, eq1_d;
  // stage 2
  logic signed [PW-1:0] bycz_q, bzcy_q, bzcx_q, bxcz_q, bxcy_q, bycx_q;
  logic signed [PW-1:0] bzbx_q, bzby_q, bxbx_q, byby_q;
  logic signed [PW-1:0] bycz_d, bzcy_d, bzcx_d, bxcz_d, bxcy_d, bycx_d;
  logic signed [PW-1:0] bzbx_d, bzby_d, bxbx_d, byby_d;
  logic signed [DW-1:0] dx2_q, dy2_q;
  logic signed [W-1:0]  z1b_q;
  logic                 eq2_q;
  // stage 3
  logic signed [NW-1:0] cnx_q, cny_q, cnz_q, lx_q, ly_q, lz_q;
  logic signed [NW-1:0] cnx_d, cny_d, cnz_d, lx_d, ly_d, lz_d;
  logic signed [DW-1:0] dx3_q, dy3_q;
  logic signed [W-1:0]  z1c_q;
  logic                 eq3_q;
  // stage 4
  logic signed [NW-1:0] nx_q, ny_q, nz_q, nx_d, ny_d, nz_d;
  logic signed [NW-1:0] sx, sy, sz;
  logic signed [DW-1:0] dx4_q, dy4_q;
  logic signed [W-1:0]  z1d_q;
  tpi_pkg::tpi_flags_t  flags_q, flags_d;
  logic                 colin;

  always_comb begin
    for (int k = 0; k < tpi_pkg::InFieldCnt; k++) begin
      f[k] = in_data_i[k*W +: W];
    end
  end

  always_comb begin
    en[NS-1] = ~v_q[NS-1] | ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_comb begin
    bx_d  = DW'(f[5]) - DW'(f[2]);
    by_d  = DW'(f[6]) - DW'(f[3]);
    bz_d  = DW'(f[7]) - DW'(f[4]);
    cx_d  = DW'(f[8]) - DW'(f[2]);
    cy_d  = DW'(f[9]) - DW'(f[3]);
    cz_d  = DW'(f[10]) - DW'(f[4]);
    dx1_d = DW'(f[0]) - DW'(f[2]);
    dy1_d = DW'(f[1]) - DW'(f[3]);
    eq1_d = (f[0] == f[2]) && (f[1] == f[3]);
  end

  always_comb begin
    bycz_d = by_q * cz_q;
    bzcy_d = bz_q * cy_q;
    bzcx_d = bz_q * cx_q;
    bxcz_d = bx_q * cz_q;
    bxcy_d = bx_q * cy_q;
    bycx_d = by_q * cx_q;
    bzbx_d = bz_q * bx_q;
    bzby_d = bz_q * by_q;
    bxbx_d = bx_q * bx_q;
    byby_d = by_q * by_q;
  end

  always_comb begin
    cnx_d = NW'(bycz_q) - NW'(bzcy_q);
    cny_d = NW'(bzcx_q) - NW'(bxcz_q);
    cnz_d = NW'(bxcy_q) - NW'(bycx_q);
    lx_d  = NW'(bzbx_q);
    ly_d  = NW'(bzby_q);
    lz_d  = -(NW'(bxbx_q) + NW'(byby_q));
  end

  always_comb begin
    colin = (cnx_q == '0) && (cny_q == '0) && (cnz_q == '0);
    sx = colin ? lx_q : cnx_q;
    sy = colin ? ly_q : cny_q;
    sz = colin ? lz_q : cnz_q;
    if (sz[NW-1]) begin
      nx_d = -sx;
      ny_d = -sy;
      nz_d = -sz;
    end else begin
      nx_d = sx;
      ny_d = sy;
      nz_d = sz;
    end
    flags_d.eq  = eq3_q;
    flags_d.deg = (sz == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      bx_q  <= bx_d;
      by_q  <= by_d;
      bz_q  <= bz_d;
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      cz_q  <= cz_d;
      dx1_q <= dx1_d;
      dy1_q <= dy1_d;
      z1a_q <= f[4];
      eq1_q <= eq1_d;
    end
    if (en[1]) begin
      bycz_q <= bycz_d;
      bzcy_q <= bzcy_d;
      bzcx_q <= bzcx_d;
      bxcz_q <= bxcz_d;
      bxcy_q <= bxcy_d;
      bycx_q <= bycx_d;
      bzbx_q <= bzbx_d;
      bzby_q <= bzby_d;
      bxbx_q <= bxbx_d;
      byby_q <= byby_d;
      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      z1b_q  <= z1a_q;
      eq2_q  <= eq1_q;
    end
    if (en[2]) begin
      cnx_q <= cnx_d;
      cny_q <= cny_d;
      cnz_q <= cnz_d;
      lx_q  <= lx_d;
      ly_q  <= ly_d;
      lz_q  <= lz_d;
      dx3_q <= dx2_q;
      dy3_q <= dy2_q;
      z1c_q <= z1b_q;
      eq3_q <= eq2_q;
    end
    if (en[3]) begin
      nx_q    <= nx_d;
      ny_q    <= ny_d;
      nz_q    <= nz_d;
      dx4_q   <= dx3_q;
      dy4_q   <= dy3_q;
      z1d_q   <= z1c_q;
      flags_q <= flags_d;
    end
  end

  assign nx_o    = nx_q;
  assign ny_o    = ny_q;
  assign nz_o    = nz_q;
  assign dx_o    = dx4_q;
  assign dy_o    = dy4_q;
  assign z1_o    = z1d_q;
  assign flags_o = flags_q;

endmodule

### hdl/tpi_numer.sv
// Numerator n.x*dx + n.y*dy from split partial products, then its magnitude.
module tpi_numer #(
  parameter int DATA_WIDTH = tpi_pkg::DataWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [2*DATA_WIDTH+2:0] nx_i,
  input  logic signed [2*DATA_WIDTH+2:0] ny_i,
  input  logic signed [2*DATA_WIDTH+2:0] nz_i,
  input  logic signed [DATA_WIDTH:0]     dx_i,
  input  logic signed [DATA_WIDTH:0]     dy_i,
  input  logic signed [DATA_WIDTH-1:0]   z1_i,
  input  tpi_pkg::tpi_flags_t            flags_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [3*DATA_WIDTH+4:0]        anum_o,
  output logic                           neg_o,
  output logic [2*DATA_WIDTH+2:0]        nz_o,
  output logic signed [DATA_WIDTH-1:0]   z1_o,
  output tpi_pkg::tpi_flags_t            flags_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W + 2;
  localparam int HW = 2 * W + 4;
  localparam int NW = 2 * W + 3;
  localparam int MW = 3 * W + 5;
  localparam int NS = 3;

  logic [NS-1:0] v_q, en;

  logic signed [PW-1:0] pxl_q, pyl_q, pxl_d, pyl_d;
  logic signed [HW-1:0] pxh_q, pyh_q, pxh_d, pyh_d;
  logic signed [MW-1:0] num_q, num_d;
  logic [MW-1:0]        anum_q, anum_d;
  logic                 neg_q;
  logic [NW-1:0]        nz5_q, nz6_q, nz7_q;
  logic signed [W-1:0]  z15_q, z16_q, z17_q;
  tpi_pkg::tpi_flags_t  fl5_q, fl6_q, fl7_q;

  always_comb begin
    en[NS-1] = ~v_q[NS-1] | ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_comb begin
    pxl_d = $signed({1'b0, nx_i[W-1:0]}) * dx_i;
    pyl_d = $signed({1'b0, ny_i[W-1:0]}) * dy_i;
    pxh_d = $signed(nx_i[NW-1:W]) * dx_i;
    pyh_d = $signed(ny_i[NW-1:W]) * dy_i;
  end

  always_comb begin
    num_d = (MW'(pxh_q) <<< W) + MW'(pxl_q) + (MW'(pyh_q) <<< W) + MW'(pyl_q);
  end

  always_comb begin
    anum_d = num_q[MW-1] ? MW'(-num_q) : MW'(num_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pxl_q <= pxl_d;
      pyl_q <= pyl_d;
      pxh_q <= pxh_d;
      pyh_q <= pyh_d;
      nz5_q <= nz_i;
      z15_q <= z1_i;
      fl5_q <= flags_i;
    end
    if (en[1]) begin
      num_q <= num_d;
      nz6_q <= nz5_q;
      z16_q <= z15_q;
      fl6_q <= fl5_q;
    end
    if (en[2]) begin
      anum_q <= anum_d;
      neg_q  <= num_q[MW-1];
      nz7_q  <= nz6_q;
      z17_q  <= z16_q;
      fl7_q  <= fl6_q;
    end
  end

  assign anum_o  = anum_q;
  assign neg_o   = neg_q;
  assign nz_o    = nz7_q;
  assign z1_o    = z17_q;
  assign flags_o = fl7_q;

endmodule

### hdl/tpi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with range check.
module tpi_div #(
  parameter int DATA_WIDTH = tpi_pkg::DataWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [3*DATA_WIDTH+4:0]      anum_i,
  input  logic                         neg_i,
  input  logic [2*DATA_WIDTH+2:0]      nz_i,
  input  logic signed [DATA_WIDTH-1:0] z1_i,
  input  tpi_pkg::tpi_flags_t          flags_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [DATA_WIDTH+1:0]        quo_o,
  output logic                         neg_o,
  output logic                         ovf_o,
  output logic signed [DATA_WIDTH-1:0] z1_o,
  output tpi_pkg::tpi_flags_t          flags_o
);

  localparam int W  = DATA_WIDTH;
  localparam int QB = W + 2;
  localparam int NW = 2 * W + 3;
  localparam int MW = 3 * W + 5;
  localparam int NS = QB + 1;

  logic [NS-1:0] v_q, en;

  logic [NW-1:0]       rem_q [NS];
  logic [NW-1:0]       rem_d [NS];
  logic [QB-1:0]       low_q [NS];
  logic [QB-1:0]       low_d [NS];
  logic [QB-1:0]       quo_q [NS];
  logic [QB-1:0]       quo_d [NS];
  logic [NW-1:0]       nz_q  [NS];
  logic signed [W-1:0] z1_q  [NS];
  logic                neg_q [NS];
  logic                ovf_q [NS];
  logic                ovf_d [NS];
  tpi_pkg::tpi_flags_t fl_q  [NS];

  always_comb begin
    en[NS-1] = ~v_q[NS-1] | ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_comb begin
    rem_d[0] = anum_i[MW-1:QB];
    low_d[0] = anum_i[QB-1:0];
    quo_d[0] = '0;
    ovf_d[0] = (anum_i[MW-1:QB] >= nz_i);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rem_q[0] <= rem_d[0];
      low_q[0] <= low_d[0];
      quo_q[0] <= quo_d[0];
      ovf_q[0] <= ovf_d[0];
      nz_q[0]  <= nz_i;
      z1_q[0]  <= z1_i;
      neg_q[0] <= neg_i;
      fl_q[0]  <= flags_i;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_step
    logic [NW:0] trial;
    logic [NW:0] diff;
    logic        ge;

    always_comb begin
      trial    = {rem_q[s-1], low_q[s-1][QB-1]};
      diff     = trial - {1'b0, nz_q[s-1]};
      ge       = (trial >= {1'b0, nz_q[s-1]});
      rem_d[s] = ge ? diff[NW-1:0] : trial[NW-1:0];
      low_d[s] = {low_q[s-1][QB-2:0], 1'b0};
      quo_d[s] = {quo_q[s-1][QB-2:0], ge};
      ovf_d[s] = ovf_q[s-1];
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        rem_q[s] <= rem_d[s];
        low_q[s] <= low_d[s];
        quo_q[s] <= quo_d[s];
        ovf_q[s] <= ovf_d[s];
        nz_q[s]  <= nz_q[s-1];
        z1_q[s]  <= z1_q[s-1];
        neg_q[s] <= neg_q[s-1];
        fl_q[s]  <= fl_q[s-1];
      end
    end
  end

  assign quo_o   = quo_q[NS-1];
  assign neg_o   = neg_q[NS-1];
  assign ovf_o   = ovf_q[NS-1];
  assign z1_o    = z1_q[NS-1];
  assign flags_o = fl_q[NS-1];

endmodule

### hdl/tpi_out.sv
// Result assembly: subtract from the first vertex, saturate, special cases.
module tpi_out #(
  parameter int DATA_WIDTH = tpi_pkg::DataWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [DATA_WIDTH+1:0]        quo_i,
  input  logic                         neg_i,
  input  logic                         ovf_i,
  input  logic signed [DATA_WIDTH-1:0] z1_i,
  input  tpi_pkg::tpi_flags_t          flags_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [DATA_WIDTH-1:0] value_o,
  output logic                         degenerate_o,
  output logic                         saturated_o
);

  localparam int W  = DATA_WIDTH;
  localparam int RW = W + 4;

  localparam logic signed [RW-1:0] MinV = {{5{1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [RW-1:0] MaxV = {{5{1'b0}}, {(W-1){1'b1}}};

  logic                v_q;
  logic                en;
  logic signed [RW-1:0] q, r;
  logic signed [W-1:0] val_q, val_d;
  logic                deg_q, deg_d, sat_q, sat_d;

  assign en      = ~v_q | ready_i;
  assign ready_o = en;
  assign valid_o = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_comb begin
    q     = neg_i ? -RW'({1'b0, quo_i}) : RW'({1'b0, quo_i});
    r     = RW'(z1_i) - q;
    val_d = z1_i;
    deg_d = 1'b0;
    sat_d = 1'b0;
    if (flags_i.eq) begin
      val_d = z1_i;
    end else if (flags_i.deg) begin
      deg_d = 1'b1;
    end else if (ovf_i) begin
      sat_d = 1'b1;
      val_d = neg_i ? MaxV[W-1:0] : MinV[W-1:0];
    end else if (r < MinV) begin
      sat_d = 1'b1;
      val_d = MinV[W-1:0];
    end else if (r > MaxV) begin
      sat_d = 1'b1;
      val_d = MaxV[W-1:0];
    end else begin
      val_d = r[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= val_d;
      deg_q <= deg_d;
      sat_q <= sat_d;
    end
  end

  assign value_o      = val_q;
  assign degenerate_o = deg_q;
  assign saturated_o  = sat_q;

endmodule

### dv/testbench.sv
// Testbench for the triangle plane interpolator core: directed and random streaming checks.
`timescale 1ns / 1ps

module testbench;

  localparam int DW = 32;
  localparam int NF = tpi_pkg::InFieldCnt;
  localparam int LATENCY = DW + 11;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic signed [191:0] wide_t;
  typedef logic [DW-1:0] tri_item_t [NF];

  typedef struct {
    logic [DW-1:0] value;
    logic          deg;
    logic          sat;
  } plane_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // query_x, query_y, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
  logic [NF*DW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // value_out
  logic [DW-1:0] m_axis_tdata;
  // degenerate, saturated
  logic [1:0] m_axis_tuser;

  plane_result_t expected_z_q[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int deg_seen = 0;
  int sat_seen = 0;
  bit calm = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  triangle_plane_interpolator_core #(.DATA_WIDTH(DW)) u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #5 clk_i = ~clk_i;

  function automatic wide_t sx(logic [DW-1:0] v);
    return wide_t'($signed(v));
  endfunction

  function automatic plane_result_t plane_z(tri_item_t it);
    plane_result_t res;
    wide_t qx, qy, x1, y1, z1, bx, by, bz, cx, cy, cz, dx, dy, nx, ny, nz, num, quo, r;
    wide_t lo, hi;
    qx = sx(it[0]); qy = sx(it[1]);
    x1 = sx(it[2]); y1 = sx(it[3]); z1 = sx(it[4]);
    res.value = it[4];
    res.deg = 1'b0;
    res.sat = 1'b0;
    if (qx == x1 && qy == y1) return res;
    bx = sx(it[5]) - x1; by = sx(it[6]) - y1; bz = sx(it[7]) - z1;
    cx = sx(it[8]) - x1; cy = sx(it[9]) - y1; cz = sx(it[10]) - z1;
    dx = qx - x1; dy = qy - y1;
    nx = by * cz - bz * cy;
    ny = bz * cx - bx * cz;
    nz = bx * cy - by * cx;
    if (nx == 0 && ny == 0 && nz == 0) begin
      nx = bz * bx;
      ny = bz * by;
      nz = -(bx * bx + by * by);
    end
    if (nz < 0) begin
      nx = -nx; ny = -ny; nz = -nz;
    end
    if (nz == 0) begin
      res.deg = 1'b1;
      return res;
    end
    num = nx * dx + ny * dy;
    quo = num / nz;
    r = z1 - quo;
    lo = -(wide_t'(1) <<< (DW - 1));
    hi = (wide_t'(1) <<< (DW - 1)) - 1;
    if (r < lo) begin
      r = lo; res.sat = 1'b1;
    end else if (r > hi) begin
      r = hi; res.sat = 1'b1;
    end
    res.value = r[DW-1:0];
    return res;
  endfunction

  task automatic send_query(tri_item_t it);
    int gap;
    logic [NF*DW-1:0] word;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    for (int i = 0; i < NF; i++) word[i*DW +: DW] = it[i];
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_z_q.push_back(plane_z(it));
    sent++;
  endtask

  function automatic logic [DW-1:0] rnd_full();
    return $urandom();
  endfunction

  function automatic logic [DW-1:0] rnd_near(logic [DW-1:0] base, int span);
    return base + DW'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic tri_item_t random_triangle();
    tri_item_t it;
    logic [DW-1:0] ox, oy, oz;
    int span;
    case ($urandom_range(0, 5))
      0: for (int i = 0; i < NF; i++) it[i] = rnd_full();
      1, 2, 3: begin
        span = (32'd1 << $urandom_range(0, 20));
        ox = ($urandom_range(0, 3) == 0) ? rnd_full() : rnd_near('0, 1 << 24);
        oy = ($urandom_range(0, 3) == 0) ? rnd_full() : rnd_near('0, 1 << 24);
        oz = ($urandom_range(0, 3) == 0) ? rnd_full() : rnd_near('0, 1 << 24);
        it[2] = ox; it[3] = oy; it[4] = oz;
        it[5] = rnd_near(ox, span); it[6] = rnd_near(oy, span); it[7] = rnd_near(oz, span);
        it[8] = rnd_near(ox, span); it[9] = rnd_near(oy, span); it[10] = rnd_near(oz, span);
        it[0] = rnd_near(ox, 4 * span); it[1] = rnd_near(oy, 4 * span);
      end
      4: begin
        for (int i = 0; i < NF; i++) it[i] = rnd_near('0, 64);
        it[8] = it[2] + 2 * (it[5] - it[2]);
        it[9] = it[3] + 2 * (it[6] - it[3]);
        if ($urandom_range(0, 1)) it[10] = it[4] + 2 * (it[7] - it[4]);
      end
      default: begin
        for (int i = 0; i < NF; i++) it[i] = rnd_full();
        if ($urandom_range(0, 1)) begin
          it[0] = it[2]; it[1] = it[3];
        end else begin
          it[10] = it[4] + (($urandom_range(0, 1)) ? 32'h7fff_0000 : 32'h8000_0000);
        end
      end
    endcase
    return it;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(1, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    plane_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      received++;
      if (expected_z_q.size() == 0) begin
        $error("result with no query outstanding: value %h", m_axis_tdata);
        errors++;
      end else begin
        exp_r = expected_z_q.pop_front();
        if (m_axis_tdata !== exp_r.value) begin
          $error("value_out: expected %h actual %h", exp_r.value, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== exp_r.deg) begin
          $error("degenerate: expected %b actual %b", exp_r.deg, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== exp_r.sat) begin
          $error("saturated: expected %b actual %b", exp_r.sat, m_axis_tuser[1]);
          errors++;
        end
        deg_seen += exp_r.deg;
        sat_seen += exp_r.sat;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  task automatic test_directed();
    tri_item_t it;
    logic [DW-1:0] ext [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    // tilted plane z = x + 2y
    it = '{32'h3_0000, 32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 32'h1_0000,
           0, 32'h1_0000, 32'h2_0000};
    send_query(it);
    // query on first vertex
    it[0] = it[2]; it[1] = it[3];
    send_query(it);
    // zero normal z, not colinear
    it = '{5, 7, 1, 1, 1, 2, 2, 2, 3, 3, 9};
    send_query(it);
    // colinear in 3D, non-vertical
    it = '{5, 7, 0, 0, 0, 1, 0, 1, 2, 0, 2};
    send_query(it);
    // all vertices coincide
    it = '{5, 7, 4, 4, 4, 4, 4, 4, 4, 4, 4};
    send_query(it);
    // steep planes that overflow both ways
    it = '{32'h7fff_ffff, 0, 0, 0, 0, 1, 0, 32'h7fff_ffff, 0, 1, 0};
    send_query(it);
    it = '{32'h8000_0000, 0, 0, 0, 0, 1, 0, 32'h7fff_ffff, 0, 1, 0};
    send_query(it);
    foreach (ext[a]) foreach (ext[b]) begin
      for (int i = 0; i < NF; i++) it[i] = (i % 2) ? ext[a] : ext[b];
      it[5] = ext[a]; it[9] = ext[(b + 1) % 4];
      send_query(it);
    end
  endtask

  task automatic test_random_planes(int n);
    repeat (n) send_query(random_triangle());
  endtask

  task automatic test_back_to_back(int n);
    calm = 1'b1;
    repeat (n) send_query(random_triangle());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_planes(1450);
    test_back_to_back(280);
    s_axis_tvalid <= 1'b0;
    while (expected_z_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("covered %0d queries, %0d results, %0d degenerate, %0d saturated",
             sent, received, deg_seen, sat_seen);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
